// ===== src/nirs_pkg.sv =====
`timescale 1ns / 1ps

package nirs_pkg;

    localparam int WORD_W       = 16;
    localparam int PIX_W        = 4;
    localparam int PIX_PER_WORD = 4;
    localparam int RUN_W        = 8;
    localparam int LANE_W       = PIX_W + RUN_W;
    localparam int ENTRY_W      = LANE_W * PIX_PER_WORD;
    localparam int CNT_W        = 15;
    localparam int WPR_W        = 6;
    localparam int RPF_W        = 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [PIX_W-1:0] PIX_BLACK = 4'h0;
    localparam logic [PIX_W-1:0] PIX_WHITE = 4'hF;
    localparam logic [RUN_W-1:0] RUN_ONE   = 8'd1;
    localparam logic [RUN_W-1:0] RUN_MAX   = 8'd255;

    localparam logic [WPR_W-1:0] WPR_RESET = 6'd24;
    localparam logic [RPF_W-1:0] RPF_RESET = 8'd96;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORDS_PER_ROW  = 2'd0,
        CFG_ROWS_PER_FRAME = 2'd1
    } t_cfg_idx;

    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
        return (r == RUN_MAX) ? RUN_MAX : r + RUN_ONE;
    endfunction

endpackage

// ===== src/nirs_ram.sv =====
`timescale 1ns / 1ps

module nirs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nibble_image_run_stats.sv =====
`timescale 1ns / 1ps

// Frame statistics over a raster of 4-bit pixels, four per 16-bit word
// (bits 15..12 leftmost). One word is taken per cycle unless o_in_stall holds it
// off; each word goes through a read of the per-column memory at its word column,
// then the run update and write-back, with forwarding when consecutive words
// hit the same column. The word that closes a frame yields one result and
// the statistics restart. Results wait in a two-entry output buffer; a
// frame-closing word is held off only while both entries would still be
// taken when its result arrives, so frames of a single word run at one word
// per cycle as long as results are taken as they appear.
// The column memory needs no clearing: the first row of each frame ignores
// the stored entries and rewrites every column that it reads.
module nibble_image_run_stats #(
    parameter int MAX_ROW_PIXELS = 128,
    parameter int MAX_ROWS       = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [nirs_pkg::WORD_W-1:0]       i_pixel_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [nirs_pkg::CNT_W-1:0]        o_black_total,
    output logic [nirs_pkg::CNT_W-1:0]        o_white_total,
    output logic [nirs_pkg::RUN_W-1:0]        o_longest_row_run,
    output logic [nirs_pkg::RUN_W-1:0]        o_longest_column_run,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nirs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    import nirs_pkg::*;

    localparam int MAX_WORDS = MAX_ROW_PIXELS / 4;
    localparam int WP_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int RP_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WC_W0     = $clog2(MAX_WORDS + 1) + 1;
    localparam int WC_W      = (WC_W0 > WPR_W) ? WC_W0 : WPR_W + 1;
    localparam int RC_W0     = $clog2(MAX_ROWS + 1) + 1;
    localparam int RC_W      = (RC_W0 > RPF_W) ? RC_W0 : RPF_W + 1;
    localparam logic [WC_W-1:0] MAX_WORDS_C = WC_W'(MAX_WORDS);
    localparam logic [RC_W-1:0] MAX_ROWS_C  = RC_W'(MAX_ROWS);

    // configuration
    logic [WPR_W-1:0] r_words_per_row;
    logic [RPF_W-1:0] r_rows_per_frame;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_per_row  <= WPR_RESET;
            r_rows_per_frame <= RPF_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WORDS_PER_ROW:  r_words_per_row  <= i_cfg_data[WPR_W-1:0];
                CFG_ROWS_PER_FRAME: r_rows_per_frame <= i_cfg_data[RPF_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WC_W-1:0] eff_words;
    logic [RC_W-1:0] eff_rows;
    logic [WC_W-1:0] wpr_ext;
    logic [RC_W-1:0] rpf_ext;

    assign wpr_ext   = WC_W'(r_words_per_row);
    assign rpf_ext   = RC_W'(r_rows_per_frame);
    assign eff_words = (wpr_ext == '0 || wpr_ext > MAX_WORDS_C) ? MAX_WORDS_C : wpr_ext;
    assign eff_rows  = (rpf_ext == '0 || rpf_ext > MAX_ROWS_C) ? MAX_ROWS_C : rpf_ext;

    // stage 0: positions and memory read
    logic [WP_W-1:0] r_word_pos;
    logic [RP_W-1:0] r_row_pos;
    logic            row_end;
    logic            frame_end;
    logic            accept;

    logic            r_s1_valid;
    logic            r_s1_last;
    logic            r_s1_row_start;
    logic            r_s1_first_row;
    logic [WP_W-1:0] r_s1_addr;
    logic [WORD_W-1:0] r_s1_word;
    logic            r_s1_fwd;
    logic [ENTRY_W-1:0] r_fwd_data;

    logic [CNT_W-1:0] r_out_black;
    logic [CNT_W-1:0] r_out_white;
    logic [RUN_W-1:0] r_out_row_run;
    logic [RUN_W-1:0] r_out_col_run;
    logic             r_out_valid;

    logic [CNT_W-1:0] r_skid_black;
    logic [CNT_W-1:0] r_skid_white;
    logic [RUN_W-1:0] r_skid_row_run;
    logic [RUN_W-1:0] r_skid_col_run;
    logic             r_skid_valid;

    logic             res_push;
    logic             res_pop;
    logic [1:0]       res_held;

    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] n_entry;

    assign row_end   = (WC_W'(r_word_pos) + WC_W'(1)) >= eff_words;
    assign frame_end = row_end && ((RC_W'(r_row_pos) + RC_W'(1)) >= eff_rows);

    // results still buffered once this edge has passed
    assign res_push = r_s1_valid && r_s1_last;
    assign res_pop  = r_out_valid && !i_out_stall;
    assign res_held = {1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, res_push}
                      - {1'b0, res_pop};

    assign o_in_stall = frame_end && (res_held >= 2'd2);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos <= '0;
            r_row_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (row_end) begin
                    r_word_pos <= '0;
                    r_row_pos  <= frame_end ? '0 : r_row_pos + RP_W'(1);
                end else begin
                    r_word_pos <= r_word_pos + WP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last      <= frame_end;
            r_s1_row_start <= (r_word_pos == '0);
            r_s1_first_row <= (r_row_pos == '0);
            r_s1_addr      <= r_word_pos;
            r_s1_word      <= i_pixel_word;
            r_s1_fwd       <= r_s1_valid && (r_s1_addr == r_word_pos);
            r_fwd_data     <= n_entry;
        end
    end

    nirs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WORDS)
    ) u_col_mem (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (n_entry),
        .i_re    (accept),
        .i_raddr (r_word_pos),
        .o_rdata (rdata)
    );

    // stage 1: run update and write-back
    logic [PIX_W-1:0] r_prev_pix;
    logic [RUN_W-1:0] r_cur_run;
    logic [RUN_W-1:0] r_best_row;
    logic [RUN_W-1:0] r_best_col;
    logic [CNT_W-1:0] r_black;
    logic [CNT_W-1:0] r_white;

    logic [PIX_W-1:0] n_prev_pix;
    logic [RUN_W-1:0] n_cur_run;
    logic [RUN_W-1:0] n_best_row;
    logic [RUN_W-1:0] n_best_col;
    logic [CNT_W-1:0] n_black;
    logic [CNT_W-1:0] n_white;

    always_comb begin
        logic [ENTRY_W-1:0] old_entry;
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   old_pix;
        logic [RUN_W-1:0]   old_run;
        logic [RUN_W-1:0]   vrun;
        logic [2:0]         nb;
        logic [2:0]         nw;

        old_entry  = r_s1_fwd ? r_fwd_data : rdata;
        n_prev_pix = r_prev_pix;
        n_cur_run  = r_cur_run;
        n_best_row = r_best_row;
        n_best_col = r_best_col;
        n_entry    = '0;
        nb         = '0;
        nw         = '0;
        for (int k = 0; k < PIX_PER_WORD; k++) begin
            pix     = r_s1_word[WORD_W-PIX_W-PIX_W*k +: PIX_W];
            old_pix = old_entry[LANE_W*k +: PIX_W];
            old_run = old_entry[LANE_W*k+PIX_W +: RUN_W];

            if (pix == PIX_BLACK) nb = nb + 3'd1;
            if (pix == PIX_WHITE) nw = nw + 3'd1;

            if (k == 0 && r_s1_row_start) begin
                n_cur_run = RUN_ONE;
            end else if (pix == n_prev_pix) begin
                n_cur_run = run_inc(n_cur_run);
            end else begin
                n_cur_run = RUN_ONE;
            end
            n_prev_pix = pix;
            if (n_cur_run > n_best_row) n_best_row = n_cur_run;

            if (r_s1_first_row || pix != old_pix) begin
                vrun = RUN_ONE;
            end else begin
                vrun = run_inc(old_run);
            end
            if (vrun > n_best_col) n_best_col = vrun;

            n_entry[LANE_W*k +: LANE_W] = {vrun, pix};
        end
        n_black = r_black + CNT_W'(nb);
        n_white = r_white + CNT_W'(nw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pix <= '0;
            r_cur_run  <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
            r_black    <= '0;
            r_white    <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_prev_pix <= '0;
                r_cur_run  <= '0;
                r_best_row <= '0;
                r_best_col <= '0;
                r_black    <= '0;
                r_white    <= '0;
            end else begin
                r_prev_pix <= n_prev_pix;
                r_cur_run  <= n_cur_run;
                r_best_row <= n_best_row;
                r_best_col <= n_best_col;
                r_black    <= n_black;
                r_white    <= n_white;
            end
        end
    end

    // result buffer: output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid  <= r_skid_valid || res_push;
            r_skid_valid <= r_skid_valid && res_push;
        end else if (res_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_black   <= r_skid_black;
                r_out_white   <= r_skid_white;
                r_out_row_run <= r_skid_row_run;
                r_out_col_run <= r_skid_col_run;
            end else begin
                r_out_black   <= n_black;
                r_out_white   <= n_white;
                r_out_row_run <= n_best_row;
                r_out_col_run <= n_best_col;
            end
        end
        if (res_push && (r_skid_valid || (r_out_valid && i_out_stall))) begin
            r_skid_black   <= n_black;
            r_skid_white   <= n_white;
            r_skid_row_run <= n_best_row;
            r_skid_col_run <= n_best_col;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_black_total        = r_out_black;
    assign o_white_total        = r_out_white;
    assign o_longest_row_run    = r_out_row_run;
    assign o_longest_column_run = r_out_col_run;

endmodule
